FILE: hw/rtl/odd_even_transposition_sorter_core_assert.svh
// Assertion macros shared by the sorter RTL.
// No dependencies; concurrent assertions are compiled out under SYNTHESIS.
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_CORE_ASSERT_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OETS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OETS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/oets_pkg.sv
// Shared types and constants for the odd-even transposition sorter.
// No dependencies.
package oets_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      is_final;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_run;
        logic                      overflowed;
    } t_out_req;

    typedef struct packed {
        logic load;
        logic sort;
        logic odd;
        logic shift;
    } t_cmd;

    typedef struct packed {
        logic swapped;
        logic last;
    } t_stat;

endpackage

FILE: hw/rtl/oets_dpath.sv
// Sorter datapath: shift-in element row, parallel compare/swap cells, shift-out.
// Depends on oets_pkg.
module oets_dpath #(
    parameter int CAPACITY = oets_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [oets_pkg::VALUE_W-1:0] i_sample,
    input  oets_pkg::t_cmd                      i_cmd,
    output oets_pkg::t_stat                     o_stat,
    output oets_pkg::t_out_req                  o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [oets_pkg::VALUE_W-1:0] r_elem [CAPACITY];
    logic signed [oets_pkg::VALUE_W-1:0] n_elem [CAPACITY];
    logic [CW-1:0]                       r_count;
    logic                                r_drop;
    logic [CAPACITY-2:0]                 w_swap;
    logic                                w_full;

    assign w_full = (r_count == CW'(CAPACITY));

    genvar k;
    generate
        for (k = 0; k < CAPACITY - 1; k++) begin : g_cell
            logic w_active;
            assign w_active = (((k % 2) == 1) ? i_cmd.odd : !i_cmd.odd)
                              && (CW'(k + 1) < r_count);
            assign w_swap[k] = w_active && (r_elem[k] > r_elem[k+1]);
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_elem[i] = r_elem[i];
        end
        if (i_cmd.load && !w_full) begin
            n_elem[0] = i_sample;
            for (int i = 1; i < CAPACITY; i++) begin
                n_elem[i] = r_elem[i-1];
            end
        end else if (i_cmd.sort) begin
            // active pairs of one phase never overlap
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (w_swap[i]) begin
                    n_elem[i]   = r_elem[i+1];
                    n_elem[i+1] = r_elem[i];
                end
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_elem[i] = r_elem[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_elem[i] <= n_elem[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_full) begin
                r_drop <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
        end else if (i_cmd.shift) begin
            r_count <= r_count - CW'(1);
            if (r_count == CW'(1)) begin
                r_drop <= 1'b0;
            end
        end
    end

    assign o_stat.swapped   = |w_swap;
    assign o_stat.last      = (r_count == CW'(1));
    assign o_out.sorted_value = r_elem[0];
    assign o_out.end_of_run   = (r_count == CW'(1));
    assign o_out.overflowed   = r_drop;

endmodule

FILE: hw/rtl/oets_ctrl.sv
// Sorter controller: load / sort / emit sequencing and handshakes.
// Depends on oets_pkg and the assertion macro header.
`include "odd_even_transposition_sorter_core_assert.svh"
module oets_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_is_final,
    input  logic            i_out_stall,
    input  oets_pkg::t_stat i_stat,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output oets_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_odd, n_odd;
    logic   r_quiet, n_quiet;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);

    assign o_cmd.load  = (r_state == ST_LOAD) && i_in_valid;
    assign o_cmd.sort  = (r_state == ST_SORT);
    assign o_cmd.odd   = r_odd;
    assign o_cmd.shift = (r_state == ST_EMIT) && !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_odd   = r_odd;
        n_quiet = r_quiet;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_is_final) begin
                    n_state = ST_SORT;
                    n_odd   = 1'b1;
                    n_quiet = 1'b0;
                end
            end
            ST_SORT: begin
                n_odd   = !r_odd;
                n_quiet = !i_stat.swapped;
                if (!i_stat.swapped && r_quiet) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_out_stall && i_stat.last) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_odd   <= 1'b1;
            r_quiet <= 1'b0;
        end else begin
            r_state <= n_state;
            r_odd   <= n_odd;
            r_quiet <= n_quiet;
        end
    end

    // final request starts a sort
    `OETS_ASSERT_NEXT(a_final_to_sort, i_clk, i_rst_n, o_cmd.load && i_is_final, r_state == ST_SORT, "final request did not start sort")
    // two quiet phases of opposite parity end the sort
    `OETS_ASSERT_NEXT(a_quiet_to_emit, i_clk, i_rst_n, (r_state == ST_SORT) && r_quiet && !i_stat.swapped, r_state == ST_EMIT, "sort did not finish after quiet round")
    // a swap keeps the sort running
    `OETS_ASSERT_NEXT(a_swap_stays, i_clk, i_rst_n, (r_state == ST_SORT) && i_stat.swapped, (r_state == ST_SORT) && !r_quiet, "sort left while still swapping")
    // last result taken returns to loading
    `OETS_ASSERT_NEXT(a_last_to_load, i_clk, i_rst_n, o_cmd.shift && i_stat.last, r_state == ST_LOAD, "batch end did not return to load")

endmodule

FILE: hw/rtl/odd_even_transposition_sorter_core.sv
// Top level of the odd-even transposition sorter.
// Depends on oets_pkg, oets_ctrl and oets_dpath.
//
//  channel  direction  handshake                   payload
//  in       to core    i_in_valid / o_in_stall     i_in  (oets_pkg::t_in_req)
//  out      from core  o_out_valid / i_out_stall   o_out (oets_pkg::t_out_req)
//
// Loading takes each valid request while the input is not stalled; a batch of N
// stored elements then sorts in phases (one compare cell per neighbor pair, one phase per
// cycle, up to N phases to order, then an odd and an even phase without swaps),
// then emits one result per cycle unless the output stalls, which holds the current
// result. Input is stalled from the final request until the last result is taken.
// Reset clears the count, overflow flag and sequencer only; no clearing pass.
module odd_even_transposition_sorter_core #(
    parameter int CAPACITY = oets_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  oets_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output oets_pkg::t_out_req o_out
);

    oets_pkg::t_cmd  w_cmd;
    oets_pkg::t_stat w_stat;

    oets_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_is_final  (i_in.is_final),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    oets_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_in.sample_value),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_out    (o_out)
    );

endmodule

FILE: dv/tb_top.sv
// Testbench for odd_even_transposition_sorter_core: random batches are pushed in and each
// sorted result is checked against a batch sorter kept in the bench.
// Depends on oets_pkg and the sorter RTL.
`timescale 1ns / 100ps

class sort_scoreboard;
    localparam int CAP = oets_pkg::CAPACITY_DEF;

    logic signed [oets_pkg::VALUE_W-1:0] batch_store [CAP];
    int unsigned                         batch_len;
    bit                                  batch_dropped;
    oets_pkg::t_out_req                  sorted_q [$];
    int                                  mismatches;

    function new();
        batch_len     = 0;
        batch_dropped = 1'b0;
        mismatches    = 0;
    endfunction

    function int pending();
        return sorted_q.size();
    endfunction

    // one odd/even compare-and-swap phase over pairs (k, k+1)
    function bit swap_phase(int unsigned first);
        logic signed [oets_pkg::VALUE_W-1:0] tmp;
        bit any_swap;
        any_swap = 1'b0;
        for (int unsigned k = first; k + 1 < batch_len; k += 2) begin
            if (batch_store[k] > batch_store[k+1]) begin
                tmp              = batch_store[k];
                batch_store[k]   = batch_store[k+1];
                batch_store[k+1] = tmp;
                any_swap         = 1'b1;
            end
        end
        return any_swap;
    endfunction

    function void note_request(oets_pkg::t_in_req req);
        oets_pkg::t_out_req res;
        bit odd_swap;
        bit even_swap;
        if (batch_len < CAP) begin
            batch_store[batch_len] = req.sample_value;
            batch_len++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (!req.is_final) return;
        do begin
            odd_swap  = swap_phase(1);
            even_swap = swap_phase(0);
        end while (odd_swap || even_swap);
        for (int unsigned k = 0; k < batch_len; k++) begin
            res.sorted_value = batch_store[k];
            res.end_of_run   = (k + 1 == batch_len);
            res.overflowed   = batch_dropped;
            sorted_q.push_back(res);
        end
        batch_len     = 0;
        batch_dropped = 1'b0;
    endfunction

    function void check_result(oets_pkg::t_out_req got);
        oets_pkg::t_out_req want;
        if (sorted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result value=%0d end=%0b ovf=%0b",
                         $time, got.sorted_value, got.end_of_run, got.overflowed);
            return;
        end
        want = sorted_q.pop_front();
        if (got.sorted_value !== want.sorted_value || got.end_of_run !== want.end_of_run ||
            got.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch exp value=%0d end=%0b ovf=%0b, got value=%0d end=%0b ovf=%0b",
                         $time, want.sorted_value, want.end_of_run, want.overflowed,
                         got.sorted_value, got.end_of_run, got.overflowed);
        end
    endfunction
endclass

module tb_top;
    localparam int CAP         = oets_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 350;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    oets_pkg::t_in_req  i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    oets_pkg::t_out_req o_out;

    sort_scoreboard sb;
    bit             tx_idles;
    bit             rx_idles;
    int             hold_seq;
    int             quiet_cycles;

    odd_even_transposition_sorter_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_req(input logic signed [31:0] value, input logic fin);
        @(negedge i_clk);
        while (tx_idles && $urandom_range(99) < 22) begin
            i_in_valid = 1'b0;
            i_in       = {$urandom, 1'($urandom)};
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_in.sample_value = value;
        i_in.is_final     = fin;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(i_in);
    endtask

    task automatic send_batch(input int len);
        for (int k = 0; k < len; k++)
            send_req(pick_value(), k == len - 1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int seen_seq;
        int hold_left;
        seen_seq    = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = rx_idles && ($urandom_range(99) < 22);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int batch_idx;
        int len;
        sb           = new();
        tx_idles     = 1'b1;
        rx_idles     = 1'b1;
        hold_seq     = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, mixed signs
        send_req(32'sh7FFF_FFFF, 1'b0);
        send_req(32'sh8000_0000, 1'b0);
        send_req(32'sd0, 1'b0);
        send_req(-32'sd1, 1'b0);
        send_req(32'sd1, 1'b1);
        // single-element batches
        send_req(32'sh8000_0000, 1'b1);
        send_req(32'sh7FFF_FFFF, 1'b1);
        // equal values
        send_req(32'sd5, 1'b0);
        send_req(-32'sd5, 1'b0);
        send_req(32'sd5, 1'b0);
        send_req(-32'sd5, 1'b1);
        // descending run
        send_req(32'sd40, 1'b0);
        send_req(32'sd30, 1'b0);
        send_req(32'sd20, 1'b0);
        send_req(32'sd10, 1'b0);
        send_req(-32'sd10, 1'b1);
        // alternating bit patterns
        send_req(32'shAAAA_AAAA, 1'b0);
        send_req(32'h5555_5555, 1'b1);

        sent      = 0;
        batch_idx = 0;
        while (sent < RAND_ITEMS) begin
            tx_idles = !(batch_idx >= 12 && batch_idx < 20);
            rx_idles = tx_idles;
            case (batch_idx)
                2:       len = CAP;
                4:       len = CAP + 1;
                7:       len = CAP + 6;
                default: len = ($urandom_range(99) < 8) ? $urandom_range(CAP + 8, CAP - 2)
                                                        : $urandom_range(8, 1);
            endcase
            if (batch_idx == 6) hold_seq++;
            if (batch_idx == 9) wait_drained();
            send_batch(len);
            sent += len;
            batch_idx++;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
